FILE: hw/rtl/hsfp_pkg.sv
// Shared constants and types for the haptic slot frame packer.
package hsfp_pkg;

  localparam int SlotCount  = 8;
  localparam int SlotW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int FrameLen   = 2 * SlotCount + 2;
  localparam int CntW       = $clog2(FrameLen);
  localparam int ModeW      = 8;
  localparam int SlotFieldW = 4;
  localparam int InTdataW   = 16;

  localparam logic       CMD_ORDER  = 1'b0;
  localparam logic       CMD_FLUSH  = 1'b1;
  localparam logic [7:0] FRAME_MARK = 8'hFF;
  localparam logic [7:0] SLOT_TAG   = 8'h01;
  localparam logic [7:0] EMPTY_BYTE = 8'h00;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } seq_state_e;

  typedef struct packed {
    logic             clr;
    logic             wr_en;
    logic [SlotW-1:0] wr_idx;
    logic [ModeW-1:0] wr_mode;
  } store_wr_t;

  typedef struct packed {
    logic             any_filled;
    logic             chk_filled;
    logic             rd_filled;
    logic [ModeW-1:0] rd_mode;
  } store_rd_t;

endpackage

FILE: hw/rtl/hsfp_slot_store.sv
// Slot store: per-slot filled flags and mode bytes with one write port and two read ports (check and read).
module hsfp_slot_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hsfp_pkg::store_wr_t       wr_i,
  input  logic [hsfp_pkg::SlotW-1:0] chk_idx_i,
  input  logic [hsfp_pkg::SlotW-1:0] rd_idx_i,
  output hsfp_pkg::store_rd_t       rd_o
);

  logic [hsfp_pkg::SlotCount-1:0] filled_q;
  logic [hsfp_pkg::SlotCount-1:0] filled_d;
  logic [hsfp_pkg::ModeW-1:0]     mode_q [hsfp_pkg::SlotCount];

  always_comb begin
    filled_d = filled_q;
    if (wr_i.clr) begin
      filled_d = '0;
    end
    if (wr_i.wr_en) begin
      filled_d[wr_i.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mode_q[wr_i.wr_idx] <= wr_i.wr_mode;
    end
  end

  assign rd_o.any_filled = |filled_q;
  assign rd_o.chk_filled = filled_q[chk_idx_i];
  assign rd_o.rd_filled  = filled_q[rd_idx_i];
  assign rd_o.rd_mode    = mode_q[rd_idx_i];

endmodule

FILE: hw/rtl/hsfp_frame_seq.sv
// Frame sequencer: takes orders and flush ticks and steps out frame bytes one per cycle while byte_ready_i is high.
module hsfp_frame_seq (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             in_cmd_i,
  input  logic [hsfp_pkg::SlotFieldW-1:0]  in_slot_i,
  input  logic [hsfp_pkg::ModeW-1:0]       in_mode_i,
  output hsfp_pkg::store_wr_t              st_wr_o,
  output logic [hsfp_pkg::SlotW-1:0]       st_chk_idx_o,
  output logic [hsfp_pkg::SlotW-1:0]       st_rd_idx_o,
  input  hsfp_pkg::store_rd_t              st_rd_i,
  output logic                             byte_valid_o,
  input  logic                             byte_ready_i,
  output logic [7:0]                       byte_data_o,
  output logic                             byte_last_o
);

  hsfp_pkg::seq_state_e           state_q, state_d;
  logic [hsfp_pkg::CntW-1:0]      cnt_q, cnt_d;
  logic                           pend_q, pend_d;
  logic [hsfp_pkg::SlotW-1:0]     pend_idx_q, pend_idx_d;
  logic [hsfp_pkg::ModeW-1:0]     pend_mode_q, pend_mode_d;
  logic                           link_q;
  logic                           accept;
  logic                           slot_ok;
  logic [hsfp_pkg::CntW-1:0]      pos;
  logic                           is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q <= 1'b0;
    end else if (cfg_we_i) begin
      link_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o   = (state_q == hsfp_pkg::ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign slot_ok      = (in_slot_i != '0) &&
                        ({1'b0, in_slot_i} <= (hsfp_pkg::SlotFieldW + 1)'(hsfp_pkg::SlotCount));
  assign st_chk_idx_o = hsfp_pkg::SlotW'(in_slot_i - hsfp_pkg::SlotFieldW'(1));

  assign pos         = cnt_q - hsfp_pkg::CntW'(1);
  assign st_rd_idx_o = pos[hsfp_pkg::SlotW:1];
  assign is_last     = (cnt_q == hsfp_pkg::CntW'(hsfp_pkg::FrameLen - 1));

  always_comb begin
    if (cnt_q == '0 || is_last) begin
      byte_data_o = hsfp_pkg::FRAME_MARK;
    end else if (!st_rd_i.rd_filled) begin
      byte_data_o = hsfp_pkg::EMPTY_BYTE;
    end else if (!pos[0]) begin
      byte_data_o = hsfp_pkg::SLOT_TAG;
    end else begin
      byte_data_o = st_rd_i.rd_mode;
    end
  end

  assign byte_last_o  = is_last;
  assign byte_valid_o = (state_q == hsfp_pkg::ST_EMIT);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    pend_mode_d = pend_mode_q;
    st_wr_o     = '0;
    case (state_q)
      hsfp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd_i == hsfp_pkg::CMD_FLUSH) begin
            if (st_rd_i.any_filled) begin
              state_d = hsfp_pkg::ST_EMIT;
              cnt_d   = '0;
              pend_d  = 1'b0;
            end
          end else if (link_q && slot_ok) begin
            if (st_rd_i.chk_filled) begin
              state_d     = hsfp_pkg::ST_EMIT;
              cnt_d       = '0;
              pend_d      = 1'b1;
              pend_idx_d  = st_chk_idx_o;
              pend_mode_d = in_mode_i;
            end else begin
              st_wr_o.wr_en   = 1'b1;
              st_wr_o.wr_idx  = st_chk_idx_o;
              st_wr_o.wr_mode = in_mode_i;
            end
          end
        end
      end
      hsfp_pkg::ST_EMIT: begin
        if (byte_ready_i) begin
          if (is_last) begin
            state_d         = hsfp_pkg::ST_IDLE;
            cnt_d           = '0;
            pend_d          = 1'b0;
            st_wr_o.clr     = 1'b1;
            st_wr_o.wr_en   = pend_q;
            st_wr_o.wr_idx  = pend_idx_q;
            st_wr_o.wr_mode = pend_mode_q;
          end else begin
            cnt_d = cnt_q + hsfp_pkg::CntW'(1);
          end
        end
      end
      default: begin
        state_d = hsfp_pkg::ST_IDLE;
        cnt_d   = '0;
        pend_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hsfp_pkg::ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q  <= pend_idx_d;
    pend_mode_q <= pend_mode_d;
  end

endmodule

FILE: hw/rtl/hsfp_out_reg.sv
// Output register stage that decouples the sequencer from the downstream stream.
module hsfp_out_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_data_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic       out_last_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       last_q;

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
      last_q <= in_last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

FILE: hw/rtl/haptic_slot_frame_packer_core.sv
// Top level of the haptic slot frame packer.
// An order for a free slot is stored at its input transfer while the link is open, and the input stays ready.
// A frame is 18 bytes, one per cycle from the sequencer byte counter while downstream accepts; the
// first byte reaches the output through the sequencer state register and the output register, and
// the input is ready again in the cycle after the last byte enters the output register.
// Downstream stalls hold back the frame bytes; reset clears the slot flags and closes the link.
module haptic_slot_frame_packer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_wdata_i,     // link_open
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [hsfp_pkg::InTdataW-1:0]   s_axis_tdata_i,  // motor_slot[3:0], vibration_mode[11:4]
  input  logic                            s_axis_tuser_i,  // command
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [7:0]                      m_axis_tdata_o,  // frame_byte[7:0]
  output logic                            m_axis_tlast_o
);

  hsfp_pkg::store_wr_t           st_wr;
  hsfp_pkg::store_rd_t           st_rd;
  logic [hsfp_pkg::SlotW-1:0]    st_chk_idx;
  logic [hsfp_pkg::SlotW-1:0]    st_rd_idx;
  logic                          byte_valid;
  logic                          byte_ready;
  logic [7:0]                    byte_data;
  logic                          byte_last;

  hsfp_slot_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (st_wr),
    .chk_idx_i (st_chk_idx),
    .rd_idx_i  (st_rd_idx),
    .rd_o      (st_rd)
  );

  hsfp_frame_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_cmd_i     (s_axis_tuser_i),
    .in_slot_i    (s_axis_tdata_i[hsfp_pkg::SlotFieldW-1:0]),
    .in_mode_i    (s_axis_tdata_i[hsfp_pkg::SlotFieldW +: hsfp_pkg::ModeW]),
    .st_wr_o      (st_wr),
    .st_chk_idx_o (st_chk_idx),
    .st_rd_idx_o  (st_rd_idx),
    .st_rd_i      (st_rd),
    .byte_valid_o (byte_valid),
    .byte_ready_i (byte_ready),
    .byte_data_o  (byte_data),
    .byte_last_o  (byte_last)
  );

  hsfp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_valid),
    .in_ready_o  (byte_ready),
    .in_data_i   (byte_data),
    .in_last_i   (byte_last),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule
